[rtl/bb3_pkg.sv]
// Shared types and constants of the 3x3 box blur: pixel and line-buffer words,
// neighbor masks, the rounding divisor table and the configuration register codes.
// No dependencies.
`default_nettype none

package bb3_pkg;

	localparam int CH_W = 8;

	// Red in the lowest byte, then green, then blue.
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	localparam int PIX_W = $bits(rgb_t);

	// One line-buffer entry: the two rows above the incoming pixel.
	typedef struct packed {
		rgb_t older;
		rgb_t newer;
	} line_t;

	// Which neighbors lie inside the frame.
	typedef struct packed {
		logic lv;
		logic rv;
		logic tv;
		logic bv;
	} nbr_t;

	typedef struct packed {
		logic emit;
		nbr_t nbr;
		logic row_end;
		logic frame_end;
	} tag_t;

	typedef struct packed {
		logic frame_end;
		logic row_end;
		rgb_t rgb;
	} result_t;

	// Configuration registers.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam int FW_W = 12;
	localparam int FH_W = 13;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
	localparam logic [FH_W-1:0] HEIGHT_LIMIT       = 13'd4096;

	// Rounded mean: ((sum + N/2) * recip) >> RECIP_SHIFT for N = 4, 6, 9.
	localparam int SUM_W       = 12;
	localparam int HALF_W      = 3;
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 16;

	localparam logic [HALF_W-1:0]  HALF_4  = 3'd2;
	localparam logic [HALF_W-1:0]  HALF_6  = 3'd3;
	localparam logic [HALF_W-1:0]  HALF_9  = 3'd4;
	localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
	localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
	localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

	typedef struct packed {
		logic [HALF_W-1:0]  half;
		logic [RECIP_W-1:0] recip;
	} divc_t;

	function automatic divc_t div_const(nbr_t nb);
		divc_t d;
		logic  c3;
		logic  r3;
		c3 = nb.lv & nb.rv;
		r3 = nb.tv & nb.bv;
		case ({c3, r3})
			2'b00: begin
				d.half  = HALF_4;
				d.recip = RECIP_4;
			end
			2'b11: begin
				d.half  = HALF_9;
				d.recip = RECIP_9;
			end
			default: begin
				d.half  = HALF_6;
				d.recip = RECIP_6;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/bb3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bb3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bb3_ctrl.sv]
// Stream position tracking and configuration registers of the box blur.
// Decides which transfers enter the pipeline and tags each with its border flags.
// Depends on bb3_pkg.
`default_nettype none

module bb3_ctrl
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	input  wire logic                     in_blank,
	input  wire rgb_t                     in_pix,
	input  wire logic                     en,
	output      logic                     take,
	output      logic [$clog2(MAX_WIDTH)-1:0] addr,
	output      rgb_t                     pix,
	output      tag_t                     tag
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [CW-1:0]   in_col_q;
	logic [FH_W-1:0] in_row_q;
	logic [CW-1:0]   out_col_q;
	logic [FH_W-1:0] out_row_q;

	logic [WW-1:0]   w_eff;
	logic [FH_W-1:0] h_eff;
	logic            flushing;
	logic            primed;
	logic [WW-1:0]   in_col_inc;
	logic            col_wrap;
	logic [WW-1:0]   out_col_inc;
	logic [FH_W-1:0] out_row_inc;
	logic            row_end;
	logic            frame_end;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (fw_q < 12'd2) begin
			w_eff = WW'(2);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		if (fh_q < 13'd2) begin
			h_eff = 13'd2;
		end else if (fh_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = fh_q;
		end
	end

	assign flushing = in_row_q >= h_eff;
	assign take     = in_valid & en & (flushing | ~in_blank);
	assign primed   = (in_row_q >= 13'd2) || (in_row_q == 13'd1 && in_col_q != '0);

	assign in_col_inc  = WW'(in_col_q) + WW'(1);
	assign col_wrap    = in_col_inc >= w_eff;
	assign out_col_inc = WW'(out_col_q) + WW'(1);
	assign out_row_inc = out_row_q + 13'd1;
	assign row_end     = out_col_inc >= w_eff;
	assign frame_end   = row_end && out_row_inc >= h_eff;

	assign addr = in_col_q;
	// Flush items carry black.
	assign pix  = flushing ? '0 : in_pix;

	always_comb begin
		tag.emit      = primed;
		tag.nbr.lv    = out_col_q != '0;
		tag.nbr.rv    = !row_end;
		tag.nbr.tv    = out_row_q != '0;
		tag.nbr.bv    = out_row_inc < h_eff;
		tag.row_end   = row_end;
		tag.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= FRAME_WIDTH_RESET;
			fh_q      <= FRAME_HEIGHT_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 13'd1;
				end else begin
					in_col_q <= CW'(in_col_inc);
				end
				if (primed) begin
					if (row_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc;
					end else begin
						out_col_q <= CW'(out_col_inc);
					end
					// Last output of the frame: restart every position.
					if (frame_end) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bb3_lane.sv]
// One color lane of the box blur: masked 3x3 sum, registered, then the rounded
// mean by reciprocal multiplication. Depends on bb3_pkg.
`default_nettype none

module bb3_lane
	import bb3_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [8:0][CH_W-1:0] taps,
	input  wire nbr_t                nbr,
	input  wire divc_t               divc,
	output      logic [CH_W-1:0]     mean
);

	localparam int PROD_W = SUM_W + RECIP_W;

	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  sum_s3;
	logic [SUM_W-1:0]  biased;
	logic [PROD_W-1:0] prod;

	// Taps are column-major: left, center, right; rows top, middle, bottom.
	always_comb begin
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (!(c == 0 && !nbr.lv) && !(c == 2 && !nbr.rv) &&
				    !(r == 0 && !nbr.tv) && !(r == 2 && !nbr.bv)) begin
					sum = sum + SUM_W'(taps[c*3 + r]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum;
		end
	end

	assign biased = sum_s3 + SUM_W'(divc.half);
	assign prod   = PROD_W'(biased) * PROD_W'(divc.recip);
	assign mean   = prod[RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

[rtl/box_blur_3x3_edge_adaptive.sv]
// 3x3 box blur over a raster-order RGB stream, one pixel per clock while the output side keeps up.
// Each output is the rounded mean of the in-frame neighbors (4, 6 or 9) per color.
// Depends on bb3_pkg, bb3_ctrl, bb3_ram, bb3_lane.
//
// Usage: send frame_width x frame_height pixels, then frame_width + 1 flush
// items; the result for pixel (r, c) is produced by the item frame_width + 1
// items later and leaves via the stage-1, window, sum and output registers.
// Blank items during the pixel phase are dropped. The block takes one item per
// clock whenever the output side keeps up; a consumer stall with a result
// waiting behind the output register parks that result in a second output
// entry, and from the next clock on the input is held until the consumer accepts the output.
// Both line buffers share one MAX_WIDTH x 48-bit RAM with one write and one
// registered read per clock, so there is no clearing pass after reset.
// Write configuration only while no item is in flight.
`default_nettype none

module box_blur_3x3_edge_adaptive
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [PIX_W-1:0]      s_tdata,  // in_red, in_green, in_blue
	input  wire logic                  s_tuser,  // blank
	// blurred output
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [PIX_W-1:0]      m_tdata,  // out_red, out_green, out_blue
	output      logic                  m_tlast,  // row_end
	output      logic                  m_tuser   // frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          en;
	logic          take;
	logic [CW-1:0] addr_c;
	rgb_t          pix_c;
	tag_t          tag_c;

	logic          valid_s1;
	logic [CW-1:0] addr_s1;
	rgb_t          pix_s1;
	tag_t          tag_s1;
	logic          byp_s1;
	line_t         byp_line_s1;
	line_t         ram_rdata;
	line_t         line_s1;
	line_t         wr_line;

	rgb_t          win_q [3][3];

	logic          valid_s2;
	tag_t          tag_s2;
	logic          valid_s3;
	divc_t         divc_s3;
	logic          row_end_s3;
	logic          frame_end_s3;

	logic [2:0][8:0][CH_W-1:0] taps;
	logic [2:0][CH_W-1:0]      mean;
	result_t       res;
	logic          out_valid_q;
	result_t       out_q;
	logic          skid_valid_q;
	result_t       skid_q;

	// Whole pipeline advances while the skid entry is free.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	bb3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_blank  (s_tuser),
		.in_pix    (rgb_t'(s_tdata)),
		.en        (en),
		.take      (take),
		.addr      (addr_c),
		.pix       (pix_c),
		.tag       (tag_c)
	);

	bb3_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (valid_s1 & en),
		.waddr (addr_s1),
		.wdata (wr_line),
		.re    (take),
		.raddr (addr_c),
		.rdata (ram_rdata)
	);

	// Forward a write that lands on the address read in the same cycle.
	assign line_s1 = byp_s1 ? byp_line_s1 : ram_rdata;

	always_comb begin
		wr_line.older = line_s1.newer;
		wr_line.newer = pix_s1;
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					taps[l][c*3 + r] = win_q[c][r][l*CH_W +: CH_W];
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		bb3_lane u_lane (
			.clk  (clk),
			.en   (en),
			.taps (taps[l]),
			.nbr  (tag_s2.nbr),
			.divc (divc_s3),
			.mean (mean[l])
		);
	end

	always_comb begin
		res.rgb.red   = mean[0];
		res.rgb.green = mean[1];
		res.rgb.blue  = mean[2];
		res.row_end   = row_end_s3;
		res.frame_end = frame_end_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			byp_s1       <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (en) begin
			valid_s1 <= take;
			byp_s1   <= take && valid_s1 && (addr_c == addr_s1);
			valid_s2 <= valid_s1 && tag_s1.emit;
			valid_s3 <= valid_s2;
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= valid_s3;
			end else begin
				out_valid_q <= valid_s3;
			end
			// Shift the window one column left and load the new column.
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[0][r] <= win_q[1][r];
					win_q[1][r] <= win_q[2][r];
				end
				win_q[2][0] <= line_s1.older;
				win_q[2][1] <= line_s1.newer;
				win_q[2][2] <= pix_s1;
			end
		end else if (m_tready) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1      <= addr_c;
			pix_s1       <= pix_c;
			tag_s1       <= tag_c;
			byp_line_s1  <= wr_line;
			tag_s2       <= tag_s1;
			divc_s3      <= div_const(tag_s2.nbr);
			row_end_s3   <= tag_s2.row_end;
			frame_end_s3 <= tag_s2.frame_end;
			if (out_valid_q && !m_tready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (m_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.rgb;
	assign m_tlast  = out_q.row_end;
	assign m_tuser  = out_q.frame_end;

endmodule

`default_nettype wire

[rtl/bb3_checker.sv]
// Port-level checks of the box blur and the bind that attaches them.
// Depends on bb3_pkg and box_blur_3x3_edge_adaptive.
`default_nettype none

module bb3_checker
	import bb3_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [PIX_W-1:0] m_tdata,
	input wire logic             m_tlast,
	input wire logic             m_tuser
);

	// The last pixel of a frame also closes its row.
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame_end without row_end");

	// An empty output stage never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// A consumer ready drains the skid entry.
	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tready) |-> s_tready)
		else $error("input still stalled after output transfer");

	// Hold a stalled result.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
			$stable(m_tlast) && $stable(m_tuser))
		else $error("output changed while stalled");

	// A valid input always sees a known ready.
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown(s_tready))
		else $error("unknown input ready");

endmodule

bind box_blur_3x3_edge_adaptive bb3_checker u_bb3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
